### rtl/ics_pkg.sv
// package: beat types, operation codes and ones'-complement helpers
`timescale 1ns / 1ps
package ics_pkg;

   localparam int SumWidth = 16;
   localparam logic [SumWidth-1:0] SumMask = 16'hFFFF;
   localparam logic [SumWidth-1:0] LowMask = 16'h00FF;
   localparam logic [SumWidth-1:0] HighMask = 16'hFF00;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      OP_ADD_BYTE = 2'd0,
      OP_MERGE    = 2'd1,
      OP_NEGATE   = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_NEGATE = 2'd1,
      CMD_HOLD   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      logic [1:0]          operation;
      logic [7:0]          data_byte;
      logic [SumWidth-1:0] partial_checksum;
      logic                offset_odd;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [SumWidth-1:0] checksum;
      logic                is_final;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [SumWidth-1:0] value;
      logic                last;
   } cmd_type;

   function automatic logic [SumWidth-1:0] oc_add(input logic [SumWidth-1:0] a,
                                                  input logic [SumWidth-1:0] b);
      logic [SumWidth:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[SumWidth-1:0] + {{(SumWidth-1){1'b0}}, t[SumWidth]};
   endfunction

endpackage

### rtl/ics_front.sv
// front end: lane tracking and classification of input beats into commands
`timescale 1ns / 1ps
module ics_front
   import ics_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  logic    accept,
   output cmd_type cmd
);

   logic lane_ff;
   logic lane_in;
   logic [SumWidth-1:0] merge_value;

   assign merge_value = ~req.partial_checksum;

   always_comb begin
      cmd.last = req.last;
      cmd.kind = CMD_HOLD;
      cmd.value = '0;
      case (op_type'(req.operation))
         OP_ADD_BYTE: begin
            cmd.kind = CMD_ADD;
            cmd.value = lane_ff ? ({req.data_byte, 8'h00} & HighMask)
                                : ({8'h00, req.data_byte} & LowMask);
         end
         OP_MERGE: begin
            cmd.kind = CMD_ADD;
            cmd.value = req.offset_odd ? {merge_value[7:0], merge_value[15:8]}
                                       : merge_value;
         end
         OP_NEGATE: begin
            cmd.kind = CMD_NEGATE;
         end
         default: begin
            cmd.kind = CMD_HOLD;
         end
      endcase
   end

   always_comb begin
      lane_in = lane_ff;
      if (accept) begin
         if (req.last) begin
            lane_in = 1'b0;
         end else if (op_type'(req.operation) == OP_ADD_BYTE) begin
            lane_in = ~lane_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff <= 1'b0;
      end else begin
         lane_ff <= lane_in;
      end
   end

endmodule

### rtl/ics_queue.sv
// short command queue between front and back end
`timescale 1ns / 1ps
module ics_queue
   import ics_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PtrWidth = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   cmd_type entry_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != CountWidth'(QueueDepth));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/ics_back.sv
// back end: running ones'-complement sum and output register
`timescale 1ns / 1ps
module ics_back
   import ics_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic [SumWidth-1:0] sum_ff, sum_in;
   logic [SumWidth-1:0] new_sum;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic take;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take = cmd_valid && cmd_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      case (cmd.kind)
         CMD_ADD: new_sum = oc_add(sum_ff, cmd.value);
         CMD_NEGATE: new_sum = SumMask ^ sum_ff;
         default: new_sum = sum_ff;
      endcase
   end

   always_comb begin
      sum_in = sum_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         sum_in = cmd.last ? '0 : new_sum;
         rsp_in.checksum = ~new_sum;
         rsp_in.is_final = cmd.last;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

### rtl/internet_checksum_stream.sv
// top level: streaming internet checksum over bytes, merges and negates
// a req beat is registered in the command queue, then in the output register that drives rsp_valid
// throughput: one beat per cycle while rsp_ready is high, with the end-around add in the back end combinational
// a two-entry command queue and the output register let each side stall on its own
// synchronous active-high reset clears the sum, the lane and all valid state
`timescale 1ns / 1ps
module internet_checksum_stream
   import ics_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic queue_valid;
   logic back_ready;
   logic req_accept;

   assign req_accept = req_valid && req_ready;

   ics_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_payload),
      .accept (req_accept),
      .cmd    (front_cmd)
   );

   ics_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (queue_cmd)
   );

   ics_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (back_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp_payload)
   );

endmodule

### bench/checksum_checker.sv
// checker: predicts the checksum of every accepted req beat and compares rsp beats in order
`timescale 1ns / 1ps
module checksum_checker
   import ics_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      fail_count,
   output int      outstanding
);

   logic [SumWidth-1:0] sum_model;
   logic                high_lane;
   rsp_type             expected_rsp[$];
   int                  fails = 0;
   int                  pending_n = 0;

   assign fail_count  = fails;
   assign outstanding = pending_n;

   // ones'-complement add, end-around by subtracting the all-ones value
   function automatic logic [SumWidth-1:0] end_around_add(input logic [SumWidth-1:0] a,
                                                         input logic [SumWidth-1:0] b);
      logic [SumWidth:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total > {1'b0, SumMask})
         total = total - {1'b0, SumMask};
      return total[SumWidth-1:0];
   endfunction

   always @(posedge clock) begin : monitor
      req_type             req_beat;
      rsp_type             got;
      rsp_type             want;
      logic [SumWidth-1:0] addend;
      if (reset) begin
         sum_model = '0;
         high_lane = 1'b0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (expected_rsp.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("unexpected rsp beat: checksum %h is_final %b",
                           got.checksum, got.is_final);
            end else begin
               want = expected_rsp.pop_front();
               if (got.checksum !== want.checksum || got.is_final !== want.is_final) begin
                  fails++;
                  if (fails <= 10)
                     $display({"rsp mismatch: expected checksum %h is_final %b, ",
                               "got checksum %h is_final %b"},
                              want.checksum, want.is_final, got.checksum, got.is_final);
               end
            end
         end
         if (req_valid && req_ready) begin
            req_beat = req_payload;
            case (op_type'(req_beat.operation))
               OP_ADD_BYTE: begin
                  addend = high_lane ? {req_beat.data_byte, 8'h00} : {8'h00, req_beat.data_byte};
                  sum_model = end_around_add(sum_model, addend);
                  high_lane = ~high_lane;
               end
               OP_MERGE: begin
                  addend = ~req_beat.partial_checksum;
                  if (req_beat.offset_odd)
                     addend = {addend[7:0], addend[15:8]};
                  sum_model = end_around_add(sum_model, addend);
               end
               OP_NEGATE: begin
                  sum_model = SumMask - sum_model;
               end
               default: begin
               end
            endcase
            want.checksum = ~sum_model;
            want.is_final = req_beat.last;
            expected_rsp.push_back(want);
            if (req_beat.last) begin
               sum_model = '0;
               high_lane = 1'b0;
            end
         end
      end
      pending_n = expected_rsp.size();
   end

endmodule

### bench/tb.sv
// testbench top: drives byte, merge, negate and no-op beats into the block and gives the verdict
`timescale 1ns / 1ps
module tb;
   import ics_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int HoldCycles  = 400;
   localparam int DrainCycles = 16;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   int fail_count;
   int outstanding;
   int cycle_count;
   bit idling;
   bit hold_request;
   bit hold_done;

   internet_checksum_stream uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   checksum_checker sum_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL internet_checksum_stream");
      $finish;
   end

   // receiver, with one long hold-off so the block backs up
   initial begin
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end else begin
            rsp_ready <= !(idling && $urandom_range(99) < 36);
         end
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] rand_word();
      return 16'($urandom_range(65535));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(1));
   endfunction

   function automatic req_type make_beat(input op_type op, input logic [7:0] data,
                                         input logic [15:0] partial, input logic odd,
                                         input logic last);
      req_type b;
      b.operation        = op;
      b.data_byte        = data;
      b.partial_checksum = partial;
      b.offset_odd       = odd;
      b.last             = last;
      return b;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(input req_type b);
      while (idling && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_streams(input int beat_count);
      int     sent;
      int     len;
      int     pick;
      bit     broken;
      op_type op;
      logic   last;
      sent = 0;
      while (sent < beat_count) begin
         len    = $urandom_range(1, 40);
         broken = ($urandom_range(9) == 0);
         for (int i = 0; i < len && sent < beat_count; i++) begin
            pick = $urandom_range(99);
            if (pick < 72)
               op = OP_ADD_BYTE;
            else if (pick < 86)
               op = OP_MERGE;
            else if (pick < 94)
               op = OP_NEGATE;
            else
               op = OP_NONE;
            if (broken)
               last = ($urandom_range(7) == 0);
            else
               last = (i == len - 1);
            send_beat(make_beat(op, rand_byte(), rand_word(), rand_bit(), last));
            sent++;
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      idling       = 1'b1;
      hold_request = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty sum, negative zero, end-around carry, lanes, merges, unused code, last
      send_beat(make_beat(OP_NONE, rand_byte(), rand_word(), 1'b1, 1'b0));
      send_beat(make_beat(OP_ADD_BYTE, 8'hFF, rand_word(), 1'b0, 1'b0));
      send_beat(make_beat(OP_ADD_BYTE, 8'hFF, rand_word(), 1'b1, 1'b0));
      send_beat(make_beat(OP_NEGATE, rand_byte(), rand_word(), 1'b0, 1'b0));
      send_beat(make_beat(OP_NEGATE, rand_byte(), rand_word(), 1'b1, 1'b0));
      send_beat(make_beat(OP_ADD_BYTE, 8'h01, rand_word(), 1'b0, 1'b0));
      send_beat(make_beat(OP_MERGE, rand_byte(), 16'h0000, 1'b0, 1'b0));
      send_beat(make_beat(OP_MERGE, rand_byte(), 16'h1234, 1'b1, 1'b0));
      send_beat(make_beat(OP_MERGE, rand_byte(), 16'hFFFF, 1'b0, 1'b0));
      send_beat(make_beat(OP_ADD_BYTE, 8'h00, rand_word(), 1'b1, 1'b0));
      send_beat(make_beat(OP_ADD_BYTE, 8'h80, rand_word(), 1'b0, 1'b1));
      send_beat(make_beat(OP_ADD_BYTE, 8'hAB, rand_word(), 1'b0, 1'b0));
      send_beat(make_beat(OP_NONE, rand_byte(), rand_word(), 1'b0, 1'b1));
      send_beat(make_beat(OP_NEGATE, rand_byte(), rand_word(), 1'b1, 1'b1));
      send_beat(make_beat(OP_MERGE, rand_byte(), 16'h00FF, 1'b1, 1'b0));
      send_beat(make_beat(OP_ADD_BYTE, 8'h7F, 16'hFFFF, 1'b1, 1'b0));
      send_beat(make_beat(OP_MERGE, 8'h00, 16'hFFFF, 1'b1, 1'b1));
      send_beat(make_beat(OP_ADD_BYTE, 8'h55, rand_word(), 1'b0, 1'b0));

      send_streams(600);

      // no idling, receiver stalls for a long stretch
      idling       = 1'b0;
      hold_request = 1'b1;
      send_streams(300);

      idling = 1'b1;
      send_streams(400);

      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("PASS internet_checksum_stream");
      else
         $display("FAIL internet_checksum_stream");
      $finish;
   end

endmodule
